// File: hdl/dtl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared widths, token kinds, keyword tables, the scanner state record and
// the token record of the token lexer.
// ----------------------------------------------------------------------------
package dtl_pkg;

	localparam int OFFSET_BITS  = 24;
	localparam int LINE_BITS    = 20;
	localparam int COLUMN_BITS  = 16;
	localparam int LEN_BITS     = 16;
	localparam int KIND_BITS    = 5;
	localparam int KW_COUNT     = 10;

	// up to three tokens per word: flushed token, new token, eof
	localparam int MAX_RES      = 3;
	localparam int RES_CNT_BITS = 2;

	// token queue
	localparam int Q_DEPTH      = 4;
	localparam int Q_PTR_BITS   = 2;
	localparam int Q_CNT_BITS   = 3;

	// token kinds
	localparam logic [KIND_BITS-1:0] K_EOF      = 5'd0;
	localparam logic [KIND_BITS-1:0] K_LBRACE   = 5'd1;
	localparam logic [KIND_BITS-1:0] K_RBRACE   = 5'd2;
	localparam logic [KIND_BITS-1:0] K_LBRACKET = 5'd3;
	localparam logic [KIND_BITS-1:0] K_RBRACKET = 5'd4;
	localparam logic [KIND_BITS-1:0] K_LPAREN   = 5'd5;
	localparam logic [KIND_BITS-1:0] K_RPAREN   = 5'd6;
	localparam logic [KIND_BITS-1:0] K_SEMI     = 5'd7;
	localparam logic [KIND_BITS-1:0] K_COMMA    = 5'd8;
	localparam logic [KIND_BITS-1:0] K_COLON    = 5'd9;
	localparam logic [KIND_BITS-1:0] K_EQUAL    = 5'd10;
	localparam logic [KIND_BITS-1:0] K_AT       = 5'd11;
	localparam logic [KIND_BITS-1:0] K_IDENT    = 5'd12;
	localparam logic [KIND_BITS-1:0] K_INT      = 5'd13;
	localparam logic [KIND_BITS-1:0] K_KW0      = 5'd14;
	localparam logic [KIND_BITS-1:0] K_INVALID  = 5'd24;

	// keyword spellings, left aligned, zero padded to eight characters
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		{"packet", 16'h0000},
		{"enum", 32'h0000_0000},
		{"uint8", 24'h00_0000},
		{"uint16", 16'h0000},
		{"uint32", 16'h0000},
		{"int8", 32'h0000_0000},
		{"int16", 24'h00_0000},
		{"int32", 24'h00_0000},
		{"float32", 8'h00},
		{"crc16", 24'h00_0000}
	};

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd6, 3'd4, 3'd5, 3'd6, 3'd6, 3'd4, 3'd5, 3'd5, 3'd7, 3'd5
	};

	typedef enum logic [6:0] {
		M_IDLE      = 7'b000_0001,
		M_SLASH     = 7'b000_0010,
		M_LINECOM   = 7'b000_0100,
		M_BLOCK     = 7'b000_1000,
		M_BLOCKSTAR = 7'b001_0000,
		M_IDENT     = 7'b010_0000,
		M_NUMBER    = 7'b100_0000
	} mode_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] pos;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		mode_t                  mode;
		logic [OFFSET_BITS-1:0] start_off;
		logic [COLUMN_BITS-1:0] start_col;
		logic [LEN_BITS-1:0]    len;
		logic [KW_COUNT-1:0]    cand;
	} state_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]   token_kind;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [LEN_BITS-1:0]    lexeme_length;
		logic [LINE_BITS-1:0]   line_number;
		logic [COLUMN_BITS-1:0] column_number;
		logic                   last_of_run;
	} tok_t;

	// state at reset and after every eof
	function automatic state_t reset_state();
		state_t s;
		s.pos       = '0;
		s.line      = LINE_BITS'(1);
		s.col       = COLUMN_BITS'(1);
		s.mode      = M_IDLE;
		s.start_off = '0;
		s.start_col = COLUMN_BITS'(1);
		s.len       = '0;
		s.cand      = '1;
		return s;
	endfunction

endpackage

// File: hdl/dtl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_in_if
// Text channel: one source byte per word, plus present and end marks.
// ----------------------------------------------------------------------------
interface dtl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       byte_present;
	logic       end_of_text;

	modport source (output valid, output text_byte, output byte_present,
		output end_of_text, input ready);
	modport sink (input valid, input text_byte, input byte_present,
		input end_of_text, output ready);
endinterface

// File: hdl/dtl_tok_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_tok_if
// Token channel: one token per word with its position fields.
// ----------------------------------------------------------------------------
interface dtl_tok_if;
	logic                             valid;
	logic                             ready;
	logic [dtl_pkg::KIND_BITS-1:0]    token_kind;
	logic [dtl_pkg::OFFSET_BITS-1:0]  start_offset;
	logic [dtl_pkg::LEN_BITS-1:0]     lexeme_length;
	logic [dtl_pkg::LINE_BITS-1:0]    line_number;
	logic [dtl_pkg::COLUMN_BITS-1:0]  column_number;
	logic                             last_of_run;

	modport source (output valid, output token_kind, output start_offset,
		output lexeme_length, output line_number, output column_number,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input lexeme_length, input line_number, input column_number,
		input last_of_run, output ready);
endinterface

// File: hdl/dtl_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_step
// One scanner step: from the current state and one text word, the next state
// and the zero to three tokens the word produces, in order.
// ----------------------------------------------------------------------------
module dtl_step (
	input  dtl_pkg::state_t                 cur,
	input  logic [7:0]                      text_byte,
	input  logic                            byte_present,
	input  logic                            end_of_text,
	output dtl_pkg::state_t                 nxt,
	output dtl_pkg::tok_t                   res [dtl_pkg::MAX_RES],
	output logic [dtl_pkg::RES_CNT_BITS-1:0] n_res
);

	function automatic dtl_pkg::tok_t make_tok(
		input logic [dtl_pkg::KIND_BITS-1:0]   kind,
		input logic [dtl_pkg::OFFSET_BITS-1:0] off,
		input logic [dtl_pkg::LEN_BITS-1:0]    len,
		input logic [dtl_pkg::LINE_BITS-1:0]   line,
		input logic [dtl_pkg::COLUMN_BITS-1:0] col
	);
		dtl_pkg::tok_t t;
		t.token_kind    = kind;
		t.start_offset  = off;
		t.lexeme_length = len;
		t.line_number   = line;
		t.column_number = col;
		t.last_of_run   = 1'b0;
		return t;
	endfunction

	function automatic logic [dtl_pkg::KIND_BITS-1:0] punct_kind(input logic [7:0] b);
		logic [dtl_pkg::KIND_BITS-1:0] k;
		case (b)
			"{":     k = dtl_pkg::K_LBRACE;
			"}":     k = dtl_pkg::K_RBRACE;
			"[":     k = dtl_pkg::K_LBRACKET;
			"]":     k = dtl_pkg::K_RBRACKET;
			"(":     k = dtl_pkg::K_LPAREN;
			")":     k = dtl_pkg::K_RPAREN;
			";":     k = dtl_pkg::K_SEMI;
			",":     k = dtl_pkg::K_COMMA;
			":":     k = dtl_pkg::K_COLON;
			"=":     k = dtl_pkg::K_EQUAL;
			"@":     k = dtl_pkg::K_AT;
			default: k = dtl_pkg::K_EOF;
		endcase
		return k;
	endfunction

	// keep the keywords whose character at pos equals b
	function automatic logic [dtl_pkg::KW_COUNT-1:0] kw_match(
		input logic [dtl_pkg::KW_COUNT-1:0] cand,
		input logic [2:0]                   pos,
		input logic [7:0]                   b
	);
		logic [dtl_pkg::KW_COUNT-1:0] keep;
		logic [5:0]                   sel;
		sel = {3'd7 - pos, 3'b000};
		for (int i = 0; i < dtl_pkg::KW_COUNT; i++) begin
			keep[i] = cand[i] && (dtl_pkg::KW_TEXT[i][sel +: 8] == b);
		end
		return keep;
	endfunction

	// identifier or keyword: lowest surviving keyword of exactly this length
	function automatic logic [dtl_pkg::KIND_BITS-1:0] ident_kind(
		input logic [dtl_pkg::KW_COUNT-1:0] cand,
		input logic [dtl_pkg::LEN_BITS-1:0] len
	);
		logic [dtl_pkg::KIND_BITS-1:0] k;
		k = dtl_pkg::K_IDENT;
		if (len[dtl_pkg::LEN_BITS-1:3] == '0) begin
			for (int i = dtl_pkg::KW_COUNT - 1; i >= 0; i--) begin
				if (cand[i] && (dtl_pkg::KW_LEN[i] == len[2:0]))
					k = dtl_pkg::K_KW0 + dtl_pkg::KIND_BITS'(i);
			end
		end
		return k;
	endfunction

	// token left pending in state s, if any
	function automatic dtl_pkg::tok_t pending_tok(input dtl_pkg::state_t s);
		logic [dtl_pkg::KIND_BITS-1:0] k;
		logic [dtl_pkg::LEN_BITS-1:0]  l;
		k = ident_kind(s.cand, s.len);
		l = s.len;
		if (s.mode == dtl_pkg::M_SLASH) begin
			k = dtl_pkg::K_INVALID;
			l = dtl_pkg::LEN_BITS'(1);
		end else if (s.mode == dtl_pkg::M_NUMBER) begin
			k = dtl_pkg::K_INT;
		end
		return make_tok(k, s.start_off, l, s.line, s.start_col);
	endfunction

	function automatic logic is_pending(input dtl_pkg::state_t s);
		return (s.mode == dtl_pkg::M_SLASH) || (s.mode == dtl_pkg::M_IDENT) ||
			(s.mode == dtl_pkg::M_NUMBER);
	endfunction

	dtl_pkg::state_t                 s;
	logic [dtl_pkg::RES_CNT_BITS-1:0] n;
	logic                            is_alpha;
	logic                            is_digit;
	logic                            is_nl;
	logic                            is_blank;
	logic                            scan_new;
	logic [dtl_pkg::KIND_BITS-1:0]   pk;

	always_comb begin
		s  = cur;
		n  = '0;
		for (int k = 0; k < dtl_pkg::MAX_RES; k++) begin
			res[k] = make_tok(dtl_pkg::K_EOF, '0, '0, '0, '0);
		end

		is_alpha = ((text_byte >= "a") && (text_byte <= "z")) ||
			((text_byte >= "A") && (text_byte <= "Z"));
		is_digit = (text_byte >= "0") && (text_byte <= "9");
		is_nl    = (text_byte == "\n");
		is_blank = (text_byte == " ") || (text_byte == "\t") ||
			(text_byte == "\r") || is_nl;
		pk       = punct_kind(text_byte);
		scan_new = 1'b0;

		if (byte_present) begin
			// continue the current mode; drop to idle on a closing byte
			unique case (s.mode)
				dtl_pkg::M_SLASH: begin
					if (text_byte == "/") begin
						s.mode = dtl_pkg::M_LINECOM;
					end else if (text_byte == "*") begin
						s.mode = dtl_pkg::M_BLOCK;
					end else begin
						res[n]   = pending_tok(s);
						n        = n + 2'd1;
						s.mode   = dtl_pkg::M_IDLE;
						scan_new = 1'b1;
					end
				end
				dtl_pkg::M_LINECOM: begin
					if (is_nl) s.mode = dtl_pkg::M_IDLE;
				end
				dtl_pkg::M_BLOCK: begin
					if (text_byte == "*") s.mode = dtl_pkg::M_BLOCKSTAR;
				end
				dtl_pkg::M_BLOCKSTAR: begin
					if (text_byte == "/") s.mode = dtl_pkg::M_IDLE;
					else if (text_byte != "*") s.mode = dtl_pkg::M_BLOCK;
				end
				dtl_pkg::M_IDENT: begin
					if (is_alpha || is_digit || (text_byte == "_")) begin
						if (s.len[dtl_pkg::LEN_BITS-1:3] == '0)
							s.cand = kw_match(s.cand, s.len[2:0], text_byte);
						else
							s.cand = '0;
						if (s.len != '1) s.len = s.len + dtl_pkg::LEN_BITS'(1);
					end else begin
						res[n]   = pending_tok(s);
						n        = n + 2'd1;
						s.mode   = dtl_pkg::M_IDLE;
						scan_new = 1'b1;
					end
				end
				dtl_pkg::M_NUMBER: begin
					if (is_digit) begin
						if (s.len != '1) s.len = s.len + dtl_pkg::LEN_BITS'(1);
					end else begin
						res[n]   = pending_tok(s);
						n        = n + 2'd1;
						s.mode   = dtl_pkg::M_IDLE;
						scan_new = 1'b1;
					end
				end
				default: begin
					s.mode   = dtl_pkg::M_IDLE;
					scan_new = 1'b1;
				end
			endcase

			// start a new lexeme from idle
			if (scan_new && !is_blank) begin
				s.start_off = s.pos;
				s.start_col = s.col;
				if (text_byte == "/") begin
					s.mode = dtl_pkg::M_SLASH;
				end else if (pk != dtl_pkg::K_EOF) begin
					res[n] = make_tok(pk, s.pos, dtl_pkg::LEN_BITS'(1), s.line, s.col);
					n      = n + 2'd1;
				end else if (is_alpha || (text_byte == "_")) begin
					s.mode = dtl_pkg::M_IDENT;
					s.cand = kw_match('1, 3'd0, text_byte);
					s.len  = dtl_pkg::LEN_BITS'(1);
				end else if (is_digit) begin
					s.mode = dtl_pkg::M_NUMBER;
					s.len  = dtl_pkg::LEN_BITS'(1);
				end else begin
					res[n] = make_tok(dtl_pkg::K_INVALID, s.pos, dtl_pkg::LEN_BITS'(1),
						s.line, s.col);
					n      = n + 2'd1;
				end
			end

			// advance position, line and column, saturating
			if (s.pos != '1) s.pos = s.pos + dtl_pkg::OFFSET_BITS'(1);
			if (is_nl) begin
				if (s.line != '1) s.line = s.line + dtl_pkg::LINE_BITS'(1);
				s.col = dtl_pkg::COLUMN_BITS'(1);
			end else if (s.col != '1) begin
				s.col = s.col + dtl_pkg::COLUMN_BITS'(1);
			end
		end

		// flush, emit eof and restart
		if (end_of_text) begin
			if (is_pending(s)) begin
				res[n] = pending_tok(s);
				n      = n + 2'd1;
			end
			res[n] = make_tok(dtl_pkg::K_EOF, s.pos, '0, s.line, s.col);
			n      = n + 2'd1;
			s      = dtl_pkg::reset_state();
		end

		if (n != '0) res[n - 2'd1].last_of_run = 1'b1;

		nxt   = s;
		n_res = n;
	end

endmodule

// File: hdl/dtl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtl_queue
// Token queue: takes up to three tokens per cycle, hands out one per word.
// ----------------------------------------------------------------------------
module dtl_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [dtl_pkg::RES_CNT_BITS-1:0] push_n,
	input  dtl_pkg::tok_t                    push_tok [dtl_pkg::MAX_RES],
	output logic [dtl_pkg::Q_CNT_BITS-1:0]   free,
	dtl_tok_if.source                        tokens
);

	dtl_pkg::tok_t                   mem_q [dtl_pkg::Q_DEPTH];
	logic [dtl_pkg::Q_PTR_BITS-1:0]  wr_q;
	logic [dtl_pkg::Q_PTR_BITS-1:0]  rd_q;
	logic [dtl_pkg::Q_CNT_BITS-1:0]  cnt_q;
	logic                            pop;
	dtl_pkg::tok_t                   head;

	assign pop  = tokens.valid && tokens.ready;
	assign free = dtl_pkg::Q_CNT_BITS'(dtl_pkg::Q_DEPTH) - cnt_q;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + dtl_pkg::Q_PTR_BITS'(push_n);
			rd_q  <= rd_q + dtl_pkg::Q_PTR_BITS'(pop);
			cnt_q <= cnt_q + dtl_pkg::Q_CNT_BITS'(push_n) - dtl_pkg::Q_CNT_BITS'(pop);
		end
	end

	// write the new tokens at consecutive slots
	always_ff @(posedge clk) begin
		for (int k = 0; k < dtl_pkg::MAX_RES; k++) begin
			if (dtl_pkg::RES_CNT_BITS'(k) < push_n)
				mem_q[wr_q + dtl_pkg::Q_PTR_BITS'(k)] <= push_tok[k];
		end
	end

	// present the oldest token
	assign head                 = mem_q[rd_q];
	assign tokens.valid         = (cnt_q != '0);
	assign tokens.token_kind    = head.token_kind;
	assign tokens.start_offset  = head.start_offset;
	assign tokens.lexeme_length = head.lexeme_length;
	assign tokens.line_number   = head.line_number;
	assign tokens.column_number = head.column_number;
	assign tokens.last_of_run   = head.last_of_run;

endmodule

// File: hdl/dsl_token_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsl_token_lexer
// Streaming lexer for the packet-description language: bytes in, tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one text word per clock cycle while the token queue has
// room for the tokens of the held word. A word enters an input register,
// and once all its tokens fit, one pass of the scan logic updates the
// scanner state and writes the zero to three tokens that the word produces
// into a four-entry token queue, from which the tokens are offered in order.
// The token port hands out one token per cycle while the consumer is ready,
// so the sustained rate is one word per cycle while each word yields at most
// one token, and a word that yields several tokens holds the token port for
// each of them: the queue's free space decides when the input register may
// step. A word with end_of_text flushes any pending token, adds an Eof token
// marked last, and returns the scanner to its reset state for the next text.
// ----------------------------------------------------------------------------
module dsl_token_lexer (
	input  logic     clk,
	input  logic     arst_n,
	dtl_in_if.sink   text,
	dtl_tok_if.source tokens
);

	logic                             valid_s1;
	logic [7:0]                       byte_s1;
	logic                             present_s1;
	logic                             end_s1;
	dtl_pkg::state_t                  state_q;
	dtl_pkg::state_t                  nxt;
	dtl_pkg::tok_t                    res [dtl_pkg::MAX_RES];
	logic [dtl_pkg::RES_CNT_BITS-1:0] n_res;
	logic [dtl_pkg::RES_CNT_BITS-1:0] push_n;
	logic [dtl_pkg::Q_CNT_BITS-1:0]   free;
	logic                             fire;

	// step when all tokens of the held word fit in the queue
	assign fire       = valid_s1 && (dtl_pkg::Q_CNT_BITS'(n_res) <= free);
	assign text.ready = !valid_s1 || fire;
	assign push_n     = fire ? n_res : '0;

	// hold the input word and the scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= dtl_pkg::reset_state();
		end else begin
			if (text.ready) valid_s1 <= text.valid;
			if (fire) state_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1    <= text.text_byte;
			present_s1 <= text.byte_present;
			end_s1     <= text.end_of_text;
		end
	end

	dtl_step u_step (
		.cur          (state_q),
		.text_byte    (byte_s1),
		.byte_present (present_s1),
		.end_of_text  (end_s1),
		.nxt          (nxt),
		.res          (res),
		.n_res        (n_res)
	);

	dtl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_tok (res),
		.free     (free),
		.tokens   (tokens)
	);

	// end of text always closes with an Eof token marked last
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_s1 |-> (n_res != '0) &&
			(res[n_res - 2'd1].token_kind == dtl_pkg::K_EOF) &&
			res[n_res - 2'd1].last_of_run)
		else $error("end of text did not close with a last Eof token");

	// end of text returns the scanner to its reset state
	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && end_s1 |=> (state_q == dtl_pkg::reset_state()))
		else $error("scanner state not restored after end of text");

	// a block comment swallows bytes without tokens
	a_block_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !end_s1 && (state_q.mode == dtl_pkg::M_BLOCK) |-> (n_res == '0))
		else $error("token produced inside a block comment");

endmodule
